// ----- rtl/rsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants and types for the ray-sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int MUL_CHUNK = 32;
  localparam int QUOT_BITS = 32;
  localparam int DIST_WIDTH = 32;

  typedef struct packed {
    logic hit;
    logic zdir;
    logic neg;
    logic ovf;
  } rsi_flags_t;

endpackage

// ----- rtl/ray_sphere_intersect.sv -----
// Throughput: one item per cycle unless stalled; the square root takes one stage per root
// bit and the divider one stage per quotient bit.
// The whole pipeline holds while a result waits under out_stall.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Nearer ray-sphere root in fixed point: dot products, wide discriminant,
// pipelined square root and division, saturation to 32 bits.
// ----------------------------------------------------------------------------
module ray_sphere_intersect import rsi_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_center_x,
  input  logic [31:0] in_center_y,
  input  logic [31:0] in_center_z,
  input  logic [30:0] in_sphere_radius,
  input  logic [31:0] in_origin_x,
  input  logic [31:0] in_origin_y,
  input  logic [31:0] in_origin_z,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [31:0] out_distance,
  output logic        out_zero_direction,
  output logic        out_saturated
);

  localparam int W   = COORD_WIDTH;
  localparam int OW  = W + 1;
  localparam int AW  = 2 * W;
  localparam int HW  = 2 * W + 2;
  localparam int CWD = 2 * W + 3;
  localparam int HMW = 2 * W + 1;
  localparam int CMW = 2 * W + 2;
  localparam int DW  = 4 * W + 3;
  localparam int RB  = 2 * W + 1;
  localparam int NW  = HW + 1;
  localparam int MW  = NW - 1 + FRAC_BITS;
  localparam int SQW = HW + AW + 2;
  localparam int FLW = $bits(rsi_flags_t);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: center - origin
  logic signed [W-1:0]  ctr [3];
  logic signed [W-1:0]  org [3];
  logic signed [W-1:0]  dir [3];
  logic signed [OW-1:0] oc_nxt [3];
  logic signed [OW-1:0] oc_r [3];
  logic signed [W-1:0]  d1_r [3];
  logic [W-2:0]         rad1_r;
  logic                 v1_r;

  assign ctr[0] = $signed(in_center_x[W-1:0]);
  assign ctr[1] = $signed(in_center_y[W-1:0]);
  assign ctr[2] = $signed(in_center_z[W-1:0]);
  assign org[0] = $signed(in_origin_x[W-1:0]);
  assign org[1] = $signed(in_origin_y[W-1:0]);
  assign org[2] = $signed(in_origin_z[W-1:0]);
  assign dir[0] = $signed(in_dir_x[W-1:0]);
  assign dir[1] = $signed(in_dir_y[W-1:0]);
  assign dir[2] = $signed(in_dir_z[W-1:0]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oc_nxt[i] = OW'(ctr[i]) - OW'(org[i]);
    end
  end

  // stage 2: products
  logic signed [2*W-1:0]  dd_nxt [3];
  logic signed [2*W:0]    do_nxt [3];
  logic signed [2*OW-1:0] oo_nxt [3];
  logic signed [2*W-1:0]  dd_r [3];
  logic signed [2*W:0]    do_r [3];
  logic signed [2*OW-1:0] oo_r [3];
  logic [2*W-3:0]         rr_r;
  logic                   v2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_nxt[i] = d1_r[i] * d1_r[i];
      do_nxt[i] = d1_r[i] * oc_r[i];
      oo_nxt[i] = oc_r[i] * oc_r[i];
    end
  end

  // stage 3: a, h, c
  logic [AW-1:0]         a_nxt;
  logic signed [HW-1:0]  h_nxt;
  logic signed [CWD-1:0] c_nxt;
  logic [AW-1:0]         a3_r;
  logic signed [HW-1:0]  h3_r;
  logic signed [CWD-1:0] c3_r;
  logic                  v3_r;

  assign a_nxt = AW'(dd_r[0]) + AW'(dd_r[1]) + AW'(dd_r[2]);
  assign h_nxt = HW'(do_r[0]) + HW'(do_r[1]) + HW'(do_r[2]);
  assign c_nxt = CWD'(oo_r[0]) + CWD'(oo_r[1]) + CWD'(oo_r[2]) - $signed(CWD'(rr_r));

  // stage 4: magnitudes for the wide products
  logic [HMW-1:0]       hm_r;
  logic [CMW-1:0]       cm_r;
  logic                 cneg4_r;
  logic                 zd4_r;
  logic [AW-1:0]        a4_r;
  logic signed [HW-1:0] h4_r;
  logic                 v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oc_r    <= oc_nxt;
      d1_r    <= dir;
      rad1_r  <= in_sphere_radius[W-2:0];
      dd_r    <= dd_nxt;
      do_r    <= do_nxt;
      oo_r    <= oo_nxt;
      rr_r    <= rad1_r * rad1_r;
      a3_r    <= a_nxt;
      h3_r    <= h_nxt;
      c3_r    <= c_nxt;
      hm_r    <= h3_r[HW-1] ? HMW'(-h3_r) : HMW'(h3_r);
      cm_r    <= c3_r[CWD-1] ? CMW'(-c3_r) : CMW'(c3_r);
      cneg4_r <= c3_r[CWD-1];
      zd4_r   <= (a3_r == '0);
      a4_r    <= a3_r;
      h4_r    <= h3_r;
    end
  end

  // stages 5..7: wide products, sideband delayed alongside
  logic [2*HMW-1:0]     hh;
  logic [AW+CMW-1:0]    ac;
  logic                 mv_r  [3];
  logic                 mcn_r [3];
  logic                 mzd_r [3];
  logic [AW-1:0]        ma_r  [3];
  logic signed [HW-1:0] mh_r  [3];

  rsi_wmul #(.AW_IN(HMW), .BW_IN(HMW)) u_mul_hh (
    .clk (clk), .en (en), .a (hm_r), .b (hm_r), .p (hh)
  );

  rsi_wmul #(.AW_IN(AW), .BW_IN(CMW)) u_mul_ac (
    .clk (clk), .en (en), .a (a4_r), .b (cm_r), .p (ac)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) mv_r[i] <= 1'b0;
    end else if (en) begin
      mv_r[0] <= v4_r;
      for (int i = 1; i < 3; i++) mv_r[i] <= mv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mcn_r[0] <= cneg4_r;
      mzd_r[0] <= zd4_r;
      ma_r[0]  <= a4_r;
      mh_r[0]  <= h4_r;
      for (int i = 1; i < 3; i++) begin
        mcn_r[i] <= mcn_r[i-1];
        mzd_r[i] <= mzd_r[i-1];
        ma_r[i]  <= ma_r[i-1];
        mh_r[i]  <= mh_r[i-1];
      end
    end
  end

  // stage 8: discriminant
  logic [DW-1:0]        disc_nxt;
  logic [DW-1:0]        disc_r;
  logic                 zd8_r;
  logic [AW-1:0]        a8_r;
  logic signed [HW-1:0] h8_r;
  logic                 v8_r;

  assign disc_nxt = mcn_r[2] ? DW'(hh) + DW'(ac) : DW'(hh) - DW'(ac);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= mv_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc_r <= disc_nxt;
      zd8_r  <= mzd_r[2];
      a8_r   <= ma_r[2];
      h8_r   <= mh_r[2];
    end
  end

  // square root
  logic                 sq_v;
  logic [RB-1:0]        root;
  logic [SQW-1:0]       sq_sb;
  logic signed [HW-1:0] hs;
  logic [AW-1:0]        as;
  logic                 hit_s;
  logic                 zd_s;

  rsi_sqrt #(.RB(RB), .SBW(SQW)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v8_r),
    .v       (disc_r[DW-2:0]),
    .sb_in   ({h8_r, a8_r, !disc_r[DW-1], zd8_r}),
    .out_vld (sq_v),
    .root    (root),
    .sb_out  (sq_sb)
  );

  assign {hs, as, hit_s, zd_s} = sq_sb;

  // numerator, sign, overflow pre-check
  logic signed [NW-1:0] num;
  logic                 nneg;
  logic [NW-2:0]        nabs;
  logic [MW-1:0]        mag;
  logic [AW-1:0]        rem0_r;
  logic [QUOT_BITS-1:0] low_r;
  logic [AW-1:0]        a9_r;
  rsi_flags_t           fl9_r;
  logic                 v9_r;

  assign num  = NW'(hs) - $signed(NW'(root));
  assign nneg = num[NW-1];
  assign nabs = nneg ? (NW-1)'(-num) : (NW-1)'(num);
  assign mag  = {nabs, FRAC_BITS'(0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r     <= AW'(mag[MW-1:QUOT_BITS]);
      low_r      <= mag[QUOT_BITS-1:0];
      a9_r       <= as;
      fl9_r.hit  <= hit_s;
      fl9_r.zdir <= zd_s;
      fl9_r.neg  <= nneg;
      fl9_r.ovf  <= AW'(mag[MW-1:QUOT_BITS]) >= as;
    end
  end

  // division
  logic                 dv_v;
  logic [QUOT_BITS-1:0] quo;
  logic [FLW-1:0]       dv_sb;
  rsi_flags_t           fl;

  rsi_div #(.AW(AW), .SBW(FLW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v9_r),
    .rem0    (rem0_r),
    .low     (low_r),
    .den     (a9_r),
    .sb_in   (fl9_r),
    .out_vld (dv_v),
    .quo     (quo),
    .sb_out  (dv_sb)
  );

  assign fl = rsi_flags_t'(dv_sb);

  // result select and saturation
  logic [DIST_WIDTH-1:0] lim;
  logic                  big;
  logic                  hit_nxt;
  logic [DIST_WIDTH-1:0] dist_nxt;
  logic                  zd_nxt;
  logic                  sat_nxt;
  logic                  out_valid_r;
  logic                  hit_r;
  logic [DIST_WIDTH-1:0] dist_r;
  logic                  zd_r;
  logic                  sat_r;

  assign lim = fl.neg ? {1'b1, (DIST_WIDTH-1)'(0)} : {1'b0, {(DIST_WIDTH-1){1'b1}}};
  assign big = fl.ovf || (DIST_WIDTH'(quo) > lim);

  always_comb begin
    hit_nxt  = fl.hit;
    zd_nxt   = 1'b0;
    sat_nxt  = 1'b0;
    dist_nxt = fl.neg ? DIST_WIDTH'(0) - DIST_WIDTH'(quo) : DIST_WIDTH'(quo);
    if (!fl.hit) begin
      dist_nxt = DIST_WIDTH'(0) - (DIST_WIDTH'(1) << FRAC_BITS);
    end else if (fl.zdir) begin
      dist_nxt = '0;
      zd_nxt   = 1'b1;
    end else if (big) begin
      dist_nxt = lim;
      sat_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
      zd_r   <= zd_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_distance       = dist_r;
  assign out_zero_direction = zd_r;
  assign out_saturated      = sat_r;

endmodule

// ----- rtl/rsi_wmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_wmul
// Pipelined wide unsigned multiplier: chunk partial products, row sums,
// final sum.
// ----------------------------------------------------------------------------
module rsi_wmul import rsi_pkg::*; #(
  parameter int AW_IN = 64,
  parameter int BW_IN = 64
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [AW_IN-1:0]         a,
  input  logic [BW_IN-1:0]         b,
  output logic [AW_IN+BW_IN-1:0]   p
);

  localparam int NA = (AW_IN + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB = (BW_IN + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int PW = AW_IN + BW_IN;

  logic [NA*MUL_CHUNK-1:0] a_ext;
  logic [NB*MUL_CHUNK-1:0] b_ext;
  logic [2*MUL_CHUNK-1:0]  pp_nxt [NA][NB];
  logic [2*MUL_CHUNK-1:0]  pp_r   [NA][NB];
  logic [PW-1:0]           row_nxt [NA];
  logic [PW-1:0]           row_r   [NA];
  logic [PW-1:0]           p_nxt;
  logic [PW-1:0]           p_r;

  assign a_ext = (NA*MUL_CHUNK)'(a);
  assign b_ext = (NB*MUL_CHUNK)'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i][j] = a_ext[i*MUL_CHUNK +: MUL_CHUNK] * b_ext[j*MUL_CHUNK +: MUL_CHUNK];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (PW'(pp_r[i][j]) << (j*MUL_CHUNK));
      end
    end
  end

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      p_nxt = p_nxt + (row_r[i] << (i*MUL_CHUNK));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r  <= pp_nxt;
      row_r <= row_nxt;
      p_r   <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ----- rtl/rsi_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root, one root bit per stage, with a sideband
// that travels alongside.
// ----------------------------------------------------------------------------
module rsi_sqrt import rsi_pkg::*; #(
  parameter int RB  = 65,
  parameter int SBW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [2*RB-1:0] v,
  input  logic [SBW-1:0]  sb_in,
  output logic            out_vld,
  output logic [RB-1:0]   root,
  output logic [SBW-1:0]  sb_out
);

  logic            vld_r  [1:RB];
  logic [2*RB-1:0] vv_r   [1:RB];
  logic [RB+1:0]   rm_r   [1:RB];
  logic [RB-1:0]   rt_r   [1:RB];
  logic [SBW-1:0]  sb_r   [1:RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic            vld_i;
    logic [2*RB-1:0] vv_i;
    logic [RB+1:0]   rm_i;
    logic [RB-1:0]   rt_i;
    logic [SBW-1:0]  sb_i;
    logic [RB+3:0]   cur;
    logic [RB+3:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign vld_i = in_vld;
      assign vv_i  = v;
      assign rm_i  = '0;
      assign rt_i  = '0;
      assign sb_i  = sb_in;
    end else begin : g_next
      assign vld_i = vld_r[k];
      assign vv_i  = vv_r[k];
      assign rm_i  = rm_r[k];
      assign rt_i  = rt_r[k];
      assign sb_i  = sb_r[k];
    end

    assign cur   = {rm_i, vv_i[2*RB-1 -: 2]};
    assign trial = {2'b00, rt_i, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vv_r[k+1] <= vv_i << 2;
        rm_r[k+1] <= ge ? (RB+2)'(cur - trial) : (RB+2)'(cur);
        rt_r[k+1] <= {rt_i[RB-2:0], ge};
        sb_r[k+1] <= sb_i;
      end
    end
  end

  assign out_vld = vld_r[RB];
  assign root    = rt_r[RB];
  assign sb_out  = sb_r[RB];

endmodule

// ----- rtl/rsi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined restoring divider, one quotient bit per stage. The user must keep
// the partial remainder below the divisor; the block does not enforce it.
// ----------------------------------------------------------------------------
module rsi_div import rsi_pkg::*; #(
  parameter int AW  = 64,
  parameter int SBW = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [AW-1:0]        rem0,
  input  logic [QUOT_BITS-1:0] low,
  input  logic [AW-1:0]        den,
  input  logic [SBW-1:0]       sb_in,
  output logic                 out_vld,
  output logic [QUOT_BITS-1:0] quo,
  output logic [SBW-1:0]       sb_out
);

  logic                 vld_r [1:QUOT_BITS];
  logic [AW-1:0]        rm_r  [1:QUOT_BITS];
  logic [QUOT_BITS-1:0] lo_r  [1:QUOT_BITS];
  logic [AW-1:0]        dn_r  [1:QUOT_BITS];
  logic [QUOT_BITS-1:0] q_r   [1:QUOT_BITS];
  logic [SBW-1:0]       sb_r  [1:QUOT_BITS];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
    logic                 vld_i;
    logic [AW-1:0]        rm_i;
    logic [QUOT_BITS-1:0] lo_i;
    logic [AW-1:0]        dn_i;
    logic [QUOT_BITS-1:0] q_i;
    logic [SBW-1:0]       sb_i;
    logic [AW:0]          cur;
    logic                 ge;

    if (k == 0) begin : g_first
      assign vld_i = in_vld;
      assign rm_i  = rem0;
      assign lo_i  = low;
      assign dn_i  = den;
      assign q_i   = '0;
      assign sb_i  = sb_in;
    end else begin : g_next
      assign vld_i = vld_r[k];
      assign rm_i  = rm_r[k];
      assign lo_i  = lo_r[k];
      assign dn_i  = dn_r[k];
      assign q_i   = q_r[k];
      assign sb_i  = sb_r[k];
    end

    assign cur = {rm_i, lo_i[QUOT_BITS-1]};
    assign ge  = cur >= {1'b0, dn_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm_r[k+1] <= ge ? AW'(cur - {1'b0, dn_i}) : AW'(cur);
        lo_r[k+1] <= lo_i << 1;
        dn_r[k+1] <= dn_i;
        q_r[k+1]  <= {q_i[QUOT_BITS-2:0], ge};
        sb_r[k+1] <= sb_i;
      end
    end
  end

  assign out_vld = vld_r[QUOT_BITS];
  assign quo     = q_r[QUOT_BITS];
  assign sb_out  = sb_r[QUOT_BITS];

endmodule

// ----- rtl/rsi_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_chk
// Port-level checks for ray_sphere_intersect, attached by bind.
// ----------------------------------------------------------------------------
module rsi_chk #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [31:0] out_distance,
  input logic        out_zero_direction,
  input logic        out_saturated
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance) && $stable(out_hit))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |->
      out_distance == (32'd0 - (32'd1 << FRAC_BITS)) && !out_zero_direction && !out_saturated)
    else $error("miss item carries wrong fields");

  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_direction |-> out_hit && out_distance == 32'd0 && !out_saturated)
    else $error("zero direction item carries wrong fields");

endmodule

bind ray_sphere_intersect rsi_chk #(.FRAC_BITS(FRAC_BITS)) u_rsi_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_hit            (out_hit),
  .out_distance       (out_distance),
  .out_zero_direction (out_zero_direction),
  .out_saturated      (out_saturated)
);
